// ===== rtl/core/dnpd_pkg.sv =====
// Shared types and constants for the delta/nibble escape pixel decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package dnpd_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int PIXEL_W  = 16;
  localparam int CFG_W    = 25;

  // Parameter defaults
  localparam int PIXEL_COUNT_BITS_DEF = 24;

  // Reset value of the pixel count register
  localparam logic [CFG_W-1:0] PIXEL_COUNT_RST = CFG_W'(1048576);

  // Command queue depth between front and back (power of two, at least 2)
  localparam int Q_DEPTH = 4;

  // Escape codes in byte-delta mode
  localparam logic [BYTE_W-1:0] ESC_WORD   = 8'h80;
  localparam logic [BYTE_W-1:0] ESC_RUN    = 8'h7F;
  localparam logic [BYTE_W-1:0] ESC_NIBBLE = 8'h81;
  // Right nibble that leaves nibble mode
  localparam logic [3:0]        NIB_EXIT   = 4'h8;

  // One pixel command: absolute value or delta on the previous pixel
  typedef struct packed {
    logic               absolute;
    logic [PIXEL_W-1:0] value;
    logic               last;
  } cmd_t;

  // Up to two commands written into the queue in one cycle
  typedef struct packed {
    logic en0;
    logic en1;
    cmd_t c0;
    cmd_t c1;
  } cmd_pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/dnpd_front.sv =====
// Front end: accepts stream bytes, tracks header/escape mode and pixel count,
// and issues pixel commands. Depends on dnpd_pkg.
`default_nettype none

module dnpd_front
  import dnpd_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              q_full,
  input  wire logic              cfg_valid,
  input  wire logic [CFG_W-1:0]  cfg_pixel_count,
  output cmd_pair_t              wr
);

  typedef enum logic [2:0] {
    M_PREV_W, M_PREV_H, M_SKIP, M_DELTA8, M_COUNT, M_WORD_LO, M_WORD_HI, M_NIBBLE
  } mode_t;

  localparam int CNT_W = (PIXEL_COUNT_BITS + 2 > CFG_W) ? PIXEL_COUNT_BITS + 2 : CFG_W;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(1) << PIXEL_COUNT_BITS;

  mode_t                       mode_r, mode_nxt;
  logic [8:0]                  rwl_r, rwl_nxt;
  logic [BYTE_W-1:0]           held_r, held_nxt;
  logic [BYTE_W-1:0]           pw_r, pw_nxt;
  logic [15:0]                 pbl_r, pbl_nxt;
  logic [PIXEL_COUNT_BITS-1:0] pd_r, pd_nxt;
  logic [CFG_W-1:0]            pixel_count_r;

  logic             accept;
  logic [CNT_W-1:0] pc_ext, eff, pd_ext;
  logic             last1, last2;
  logic [15:0]      prod;
  logic [3:0]       nib_l, nib_r;
  logic [8:0]       rwl_dec;
  logic [15:0]      pbl_dec;
  cmd_pair_t        wr_c;

  assign accept = in_push & ~q_full;

  // Effective image size and end-of-image checks for one or two pixels
  assign pc_ext = CNT_W'(pixel_count_r);
  assign eff    = (pixel_count_r == '0) ? CNT_W'(1) : ((pc_ext > LIMIT) ? LIMIT : pc_ext);
  assign pd_ext = CNT_W'(pd_r);
  assign last1  = (pd_ext + CNT_W'(1)) >= eff;
  assign last2  = (pd_ext + CNT_W'(2)) >= eff;

  assign prod    = 16'(pw_r) * 16'(in_data_byte);
  assign nib_l   = in_data_byte[7:4];
  assign nib_r   = in_data_byte[3:0];
  assign rwl_dec = rwl_r - 9'd1;
  assign pbl_dec = pbl_r - 16'd1;

  // Byte classification and next state
  always_comb begin
    mode_nxt = mode_r;
    rwl_nxt  = rwl_r;
    held_nxt = held_r;
    pw_nxt   = pw_r;
    pbl_nxt  = pbl_r;
    pd_nxt   = pd_r;
    wr_c     = '0;
    case (mode_r)
      M_PREV_W: begin
        pw_nxt   = in_data_byte;
        mode_nxt = M_PREV_H;
      end
      M_PREV_H: begin
        pbl_nxt  = prod;
        mode_nxt = (prod != '0) ? M_SKIP : M_DELTA8;
      end
      M_SKIP: begin
        pbl_nxt = pbl_dec;
        if (pbl_dec == '0) begin
          mode_nxt = M_DELTA8;
        end
      end
      M_DELTA8: begin
        if (in_data_byte == ESC_WORD) begin
          rwl_nxt  = 9'd1;
          mode_nxt = M_WORD_LO;
        end else if (in_data_byte == ESC_RUN) begin
          mode_nxt = M_COUNT;
        end else if (in_data_byte == ESC_NIBBLE) begin
          mode_nxt = M_NIBBLE;
        end else begin
          wr_c.en0         = 1'b1;
          wr_c.c0.absolute = 1'b0;
          wr_c.c0.value    = {{8{in_data_byte[7]}}, in_data_byte};
          wr_c.c0.last     = last1;
          pd_nxt           = pd_r + PIXEL_COUNT_BITS'(1);
        end
      end
      M_COUNT: begin
        rwl_nxt  = (in_data_byte == '0) ? 9'd256 : 9'(in_data_byte);
        mode_nxt = M_WORD_LO;
      end
      M_WORD_LO: begin
        held_nxt = in_data_byte;
        mode_nxt = M_WORD_HI;
      end
      M_WORD_HI: begin
        rwl_nxt          = rwl_dec;
        mode_nxt         = (rwl_dec != '0) ? M_WORD_LO : M_DELTA8;
        wr_c.en0         = 1'b1;
        wr_c.c0.absolute = 1'b1;
        wr_c.c0.value    = {in_data_byte, held_r};
        wr_c.c0.last     = last1;
        pd_nxt           = pd_r + PIXEL_COUNT_BITS'(1);
      end
      M_NIBBLE: begin
        wr_c.en0         = 1'b1;
        wr_c.c0.absolute = 1'b0;
        wr_c.c0.value    = {{12{nib_l[3]}}, nib_l};
        wr_c.c0.last     = last1;
        pd_nxt           = pd_r + PIXEL_COUNT_BITS'(1);
        if (!last1) begin
          if (nib_r == NIB_EXIT) begin
            mode_nxt = M_DELTA8;
          end else begin
            wr_c.en1         = 1'b1;
            wr_c.c1.absolute = 1'b0;
            wr_c.c1.value    = {{12{nib_r[3]}}, nib_r};
            wr_c.c1.last     = last2;
            pd_nxt           = pd_r + PIXEL_COUNT_BITS'(2);
          end
        end
      end
      default: begin
        mode_nxt = M_PREV_W;
      end
    endcase
    // End of image: back to header parsing, pending work dropped
    if ((wr_c.en0 && wr_c.c0.last) || (wr_c.en1 && wr_c.c1.last)) begin
      mode_nxt = M_PREV_W;
      rwl_nxt  = '0;
      held_nxt = '0;
      pw_nxt   = '0;
      pbl_nxt  = '0;
      pd_nxt   = '0;
    end
  end

  assign wr.en0 = wr_c.en0 & accept;
  assign wr.en1 = wr_c.en1 & accept;
  assign wr.c0  = wr_c.c0;
  assign wr.c1  = wr_c.c1;

  // Decoder state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PREV_W;
      rwl_r  <= '0;
      held_r <= '0;
      pw_r   <= '0;
      pbl_r  <= '0;
      pd_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      rwl_r  <= rwl_nxt;
      held_r <= held_nxt;
      pw_r   <= pw_nxt;
      pbl_r  <= pbl_nxt;
      pd_r   <= pd_nxt;
    end
  end

  // Pixel count register; the port is always ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= PIXEL_COUNT_RST;
    end else if (cfg_valid) begin
      pixel_count_r <= cfg_pixel_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dnpd_cmd_queue.sv =====
// Command queue between front and back: two writes, one read per cycle.
// Depends on dnpd_pkg.
`default_nettype none

module dnpd_cmd_queue
  import dnpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_pair_t wr,
  input  wire logic      rd,
  output cmd_t           head,
  output logic           nonempty,
  output logic           full
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wp_plus1;

  assign wp_plus1 = wp_r + PTR_W'(1);
  assign head     = mem_r[rp_r];
  assign nonempty = (cnt_r != '0);
  // Room for a two-pixel byte is required before accepting any byte
  assign full     = (cnt_r > CNT_W'(Q_DEPTH - 2));

  // Pointer and fill bookkeeping
  always_comb begin
    wp_nxt  = wp_r + PTR_W'(wr.en0) + PTR_W'(wr.en1);
    rp_nxt  = rp_r + PTR_W'(rd);
    cnt_nxt = cnt_r + CNT_W'(wr.en0) + CNT_W'(wr.en1) - CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr.en0) begin
      mem_r[wp_r] <= wr.c0;
    end
    if (wr.en1) begin
      mem_r[wp_plus1] <= wr.c1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dnpd_back.sv =====
// Back end: applies pixel commands to the running value and holds the
// output register. Depends on dnpd_pkg.
`default_nettype none

module dnpd_back
  import dnpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               head,
  input  wire logic               q_nonempty,
  output logic                    q_rd,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output logic [PIXEL_W-1:0]      out_pixel,
  output logic                    out_last_pixel
);

  logic               valid_r;
  logic [PIXEL_W-1:0] pixel_r, prev_r, pixel_nxt;
  logic               last_r;

  // Load when the output slot is free or being drained this cycle
  assign q_rd      = q_nonempty & (~valid_r | out_pop);
  assign pixel_nxt = head.absolute ? head.value : (prev_r + head.value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prev_r  <= '0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
      prev_r  <= head.last ? '0 : pixel_nxt;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (q_rd) begin
      pixel_r <= pixel_nxt;
      last_r  <= head.last;
    end
  end

  assign out_empty      = ~valid_r;
  assign out_pixel      = pixel_r;
  assign out_last_pixel = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/delta_nibble_escape_pixel_decoder.sv =====
// Delta/nibble escape pixel decoder, top level.
//
// Input: one compressed byte per transfer on in_data_byte (push/full).
// Each image is a preview width byte, a preview height byte, width*height
// skipped preview bytes, then delta-coded pixels with escapes for raw words,
// raw word runs and nibble mode. Results: 16-bit pixels on out_pixel with
// out_last_pixel on the final pixel of each image (empty/pop).
// Config: cfg_pixel_count (pixels per image) written when cfg_valid is high;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while full is low; a nibble byte yields two
// pixels, so the sustained rate is bounded by the single-pixel-per-cycle
// output register. A pixel goes through the queue, then the output register.
// full is asserted when the 4-entry command queue cannot take two pixels.
// If the receiver stalls, the output register holds and the queue fills,
// then full rises; nothing is lost. Reset clears the decoder to expect a
// preview width byte and sets pixel_count to 1048576.
// Depends on dnpd_pkg, dnpd_front, dnpd_cmd_queue, dnpd_back.
`default_nettype none

module delta_nibble_escape_pixel_decoder
  import dnpd_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [PIXEL_W-1:0]      out_pixel,
  output logic                    out_last_pixel,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_pixel_count
);

  cmd_pair_t wr;
  cmd_t      head;
  logic      q_nonempty, q_full, q_rd;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;

  dnpd_front #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_data_byte   (in_data_byte),
    .q_full         (q_full),
    .cfg_valid      (cfg_valid),
    .cfg_pixel_count(cfg_pixel_count),
    .wr             (wr)
  );

  dnpd_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (q_rd),
    .head    (head),
    .nonempty(q_nonempty),
    .full    (q_full)
  );

  dnpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_nonempty    (q_nonempty),
    .q_rd          (q_rd),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_pixel     (out_pixel),
    .out_last_pixel(out_last_pixel)
  );

endmodule

`default_nettype wire

// ===== dv/dnpd_pixel_checker.sv =====
// Pixel checker for the delta/nibble escape pixel decoder: watches the byte,
// pixel and pixel-count channels, decodes accepted bytes and compares pixels.
// Depends on dnpd_pkg for widths and escape codes.
`default_nettype none

module dnpd_pixel_checker
  import dnpd_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire logic               in_full,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  input  wire logic               out_empty,
  input  wire logic               out_pop,
  input  wire logic [PIXEL_W-1:0] out_pixel,
  input  wire logic               out_last_pixel,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_pixel_count,
  output int                      fail_count,
  output int                      pending_count
);

  localparam int MAX_PRINTS = 40;

  typedef enum logic [2:0] {
    ST_PREV_W, ST_PREV_H, ST_SKIP, ST_DELTA8,
    ST_COUNT, ST_WORD_LO, ST_WORD_HI, ST_NIBBLE
  } dec_state_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pixel_res_t;

  // Decoder copy
  dec_state_t                  dec_state;
  logic [PIXEL_W-1:0]          prev_pixel;
  logic [8:0]                  words_left;
  logic [BYTE_W-1:0]           low_byte;
  logic [BYTE_W-1:0]           prev_width;
  logic [15:0]                 skip_left;
  logic [PIXEL_COUNT_BITS-1:0] pixels_done;
  logic [CFG_W-1:0]            pixel_count;

  pixel_res_t expected_pixels[$];

  task automatic report_error(input string msg);
    if (fail_count < MAX_PRINTS) $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_decoder();
    dec_state   = ST_PREV_W;
    prev_pixel  = '0;
    words_left  = '0;
    low_byte    = '0;
    prev_width  = '0;
    skip_left   = '0;
    pixels_done = '0;
  endtask

  // Count 0 acts as 1, anything above 2^PIXEL_COUNT_BITS is clamped
  function automatic longint unsigned image_pixels();
    longint unsigned lim;
    longint unsigned c;
    lim = 64'd1 << PIXEL_COUNT_BITS;
    c = 64'(pixel_count);
    if (c == 0) c = 1;
    if (c > lim) c = lim;
    return c;
  endfunction

  // Queue one expected pixel; end of image restarts the decoder
  task automatic emit_pixel(input logic [PIXEL_W-1:0] value, output bit ended);
    longint unsigned nxt;
    nxt = 64'(pixels_done) + 64'd1;
    ended = (nxt >= image_pixels());
    expected_pixels.push_back('{pixel: value, last: ended});
    prev_pixel = value;
    if (ended) clear_decoder();
    else pixels_done = nxt[PIXEL_COUNT_BITS-1:0];
  endtask

  function automatic logic [PIXEL_W-1:0] nib_delta(input logic [3:0] nib);
    return {{12{nib[3]}}, nib};
  endfunction

  // Decode one accepted byte
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    bit ended;
    case (dec_state)
      ST_PREV_W: begin
        prev_width = b;
        dec_state  = ST_PREV_H;
      end
      ST_PREV_H: begin
        skip_left  = {8'd0, prev_width} * {8'd0, b};
        prev_pixel = '0;
        dec_state  = (skip_left != 0) ? ST_SKIP : ST_DELTA8;
      end
      ST_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) dec_state = ST_DELTA8;
      end
      ST_DELTA8: begin
        if (b == ESC_WORD) begin
          words_left = 9'd1;
          dec_state  = ST_WORD_LO;
        end else if (b == ESC_RUN) begin
          dec_state = ST_COUNT;
        end else if (b == ESC_NIBBLE) begin
          dec_state = ST_NIBBLE;
        end else begin
          emit_pixel(prev_pixel + {{8{b[7]}}, b}, ended);
        end
      end
      ST_COUNT: begin
        words_left = (b == 0) ? 9'd256 : {1'b0, b};
        dec_state  = ST_WORD_LO;
      end
      ST_WORD_LO: begin
        low_byte  = b;
        dec_state = ST_WORD_HI;
      end
      ST_WORD_HI: begin
        words_left = words_left - 9'd1;
        dec_state  = (words_left != 0) ? ST_WORD_LO : ST_DELTA8;
        emit_pixel({b, low_byte}, ended);
      end
      default: begin
        // left nibble first; a right nibble is dropped if the image ended
        emit_pixel(prev_pixel + nib_delta(b[7:4]), ended);
        if (!ended) begin
          if (b[3:0] == NIB_EXIT) dec_state = ST_DELTA8;
          else emit_pixel(prev_pixel + nib_delta(b[3:0]), ended);
        end
      end
    endcase
  endtask

  task automatic check_pixel();
    pixel_res_t want;
    if (expected_pixels.size() == 0) begin
      report_error($sformatf("pixel %h last %b with none expected", out_pixel, out_last_pixel));
    end else begin
      want = expected_pixels.pop_front();
      if (out_pixel !== want.pixel)
        report_error($sformatf("pixel got %h expected %h", out_pixel, want.pixel));
      if (out_last_pixel !== want.last)
        report_error($sformatf("last_pixel got %b expected %b on pixel %h",
                               out_last_pixel, want.last, want.pixel));
    end
  endtask

  // Transfers seen at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      pixel_count = PIXEL_COUNT_RST;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (out_pop && !out_empty) check_pixel();
      if (cfg_valid && cfg_ready) pixel_count = cfg_pixel_count;
      if (in_push && !in_full) decode_byte(in_data_byte);
    end
    pending_count = expected_pixels.size();
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Top of the pixel decoder testbench: clock, reset, byte stimulus, receiver
// stalls, pixel-count writes and the verdict. Depends on dnpd_pkg, the
// decoder RTL and dnpd_pixel_checker.
`default_nettype none

module testbench;
  import dnpd_pkg::*;

  localparam int PCB            = PIXEL_COUNT_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum int {POP_STEADY, POP_COIN, POP_SPARSE} pop_style_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [BYTE_W-1:0]  in_data_byte;
  logic               out_empty;
  logic               out_pop;
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_last_pixel;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_pixel_count;
  int                 fail_count;
  int                 pending_count;

  // Stimulus bookkeeping
  int              quiet_cycles = 0;
  int              burst_left   = 1;
  int              useful_items = 0;
  bit              need_header  = 1'b1;
  bit              hold_due     = 1'b0;
  bit              long_run_due = 1'b0;
  longint unsigned img_done     = 0;
  longint unsigned img_pixels   = 1048576;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  delta_nibble_escape_pixel_decoder #(.PIXEL_COUNT_BITS(PCB)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel       (out_pixel),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_pixel_count (cfg_pixel_count)
  );

  dnpd_pixel_checker #(.PIXEL_COUNT_BITS(PCB)) i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel       (out_pixel),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_pixel_count (cfg_pixel_count),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  function automatic longint unsigned clamp_count(input logic [CFG_W-1:0] v);
    longint unsigned lim;
    longint unsigned c;
    lim = 64'd1 << PCB;
    c = 64'(v);
    if (c == 0) c = 1;
    if (c > lim) c = lim;
    return c;
  endfunction

  // One byte transfer, then the sender's burst/gap pattern
  task automatic push_byte(input logic [BYTE_W-1:0] b, input bit ignored);
    int gap;
    in_push      <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    if (!ignored) useful_items++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Track image position so random streams stay in sync with image ends
  task automatic note_pixel(output bit ended);
    img_done++;
    ended = (img_done >= img_pixels);
    if (ended) begin
      img_done    = 0;
      need_header = 1'b1;
    end
  endtask

  // Pixel-count write, only with the block drained
  task automatic set_pixel_count(input logic [CFG_W-1:0] v);
    in_push <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_pixel_count <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    img_pixels = clamp_count(v);
  endtask

  task automatic send_header();
    int sel;
    int w;
    int h;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      w = $urandom_range(0, 3);
      h = $urandom_range(0, 3);
    end else if (sel < 80) begin
      w = $urandom_range(0, 255);
      h = 0;
    end else if (sel < 90) begin
      w = 0;
      h = $urandom_range(0, 255);
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end
    push_byte(w[7:0], 1'b0);
    push_byte(h[7:0], 1'b0);
    repeat (w * h) push_byte(8'($urandom_range(0, 255)), 1'b1);
    need_header = 1'b0;
  endtask

  // One well-formed token; image ends may cut it short
  task automatic send_token();
    int         sel;
    int         n;
    int         words;
    int         r;
    bit         ended;
    logic [7:0] b;
    logic [3:0] lft;
    logic [3:0] rgt;
    ended = 1'b0;
    if (need_header) begin
      send_header();
    end else begin
      sel = long_run_due ? 70 : $urandom_range(0, 99);
      if (sel < 60) begin
        do b = 8'($urandom_range(0, 255));
        while (b == ESC_WORD || b == ESC_RUN || b == ESC_NIBBLE);
        push_byte(b, 1'b0);
        note_pixel(ended);
      end else if (sel < 68) begin
        push_byte(ESC_WORD, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        note_pixel(ended);
      end else if (sel < 78) begin
        n = long_run_due ? 0 : $urandom_range(1, 6);
        long_run_due = 1'b0;
        words = (n == 0) ? 256 : n;
        push_byte(ESC_RUN, 1'b0);
        push_byte(n[7:0], 1'b0);
        for (int k = 0; k < words && !ended; k++) begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
          push_byte(8'($urandom_range(0, 255)), 1'b0);
          note_pixel(ended);
        end
      end else begin
        push_byte(ESC_NIBBLE, 1'b0);
        n = $urandom_range(1, 8);
        for (int k = 0; k < n && !ended; k++) begin
          r   = $urandom_range(0, 14);
          rgt = r[3:0] + ((r >= 8) ? 4'd1 : 4'd0);
          lft = 4'($urandom_range(0, 15));
          push_byte({lft, rgt}, 1'b0);
          note_pixel(ended);
          if (!ended) note_pixel(ended);
        end
        if (!ended) begin
          lft = 4'($urandom_range(0, 15));
          push_byte({lft, NIB_EXIT}, 1'b0);
          note_pixel(ended);
        end
      end
    end
  endtask

  // New pixel count, then random tokens; the long receiver hold starts
  // once the sender is running
  task automatic run_phase(input logic [CFG_W-1:0] count, input int items, input bit hold);
    int start;
    set_pixel_count(count);
    if (hold) hold_due = 1'b1;
    start = useful_items;
    while (useful_items - start < items) send_token();
  endtask

  // Idle watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("delta_nibble_escape_pixel_decoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall pattern of its own, plus one long hold on request
  initial begin : receiver
    int         len;
    pop_style_t style;
    @(posedge rst_n);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_pop <= 1'b0;
        end
      end else begin
        len   = $urandom_range(4, 40);
        style = pop_style_t'($urandom_range(0, 2));
        repeat (len) begin
          @(negedge clk);
          case (style)
            POP_STEADY: out_pop <= 1'b1;
            POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
            default:    out_pop <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Main stimulus
  initial begin
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_data_byte    = '0;
    out_pop         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_pixel_count = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one skipped preview byte, delta extremes and wrap
    push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    // single raw word, then a run of two
    push_byte(ESC_WORD, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(ESC_RUN, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    // nibble mode: left nibble of 8 is a delta, right nibble of 8 exits
    push_byte(ESC_NIBBLE, 1'b0);
    push_byte(8'h87, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte({4'h8, NIB_EXIT}, 1'b0);
    // count of zero, lowered below the pixels already done: next pixel is last
    set_pixel_count('0);
    push_byte(8'h05, 1'b0);
    // empty preview, image ends on the left nibble and the right is dropped
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(ESC_NIBBLE, 1'b0);
    push_byte(8'h12, 1'b0);
    need_header = 1'b1;
    img_done    = 0;

    // Random phases; the 256-word run is cut short by a small image
    run_phase(CFG_W'($urandom_range(2, 40)), 120, 1'b1);
    run_phase(CFG_W'(1), 40, 1'b0);
    run_phase({CFG_W{1'b1}}, 40, 1'b0);
    run_phase(CFG_W'($urandom_range(41, 300)), 100, 1'b0);
    run_phase(CFG_W'(16777216), 30, 1'b0);
    long_run_due = 1'b1;
    run_phase(CFG_W'($urandom_range(2, 12)), 80, 1'b0);

    // Drain and verdict
    in_push <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("delta_nibble_escape_pixel_decoder verification clean");
    end else begin
      $display("delta_nibble_escape_pixel_decoder verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
